/* hw/rtl/qpa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package qpa_pkg;

    // Result field widths, fixed by the output format
    localparam int PERIM_W    = 19;
    localparam int AREA_W     = 33;
    localparam int OUT_DATA_W = 56;   // 19 + 33 + 1 + 1 = 54, padded to 7 bytes

    // Results that are known before the side roots, carried beside the root pipe
    typedef struct packed {
        logic [AREA_W-1:0] double_area;
        logic              is_rhombus;
    } qpa_side_t;

endpackage

`default_nettype wire

/* hw/rtl/qpa_front.sv */
`timescale 1ns / 1ps
`default_nettype none

// Four-stage front end: side differences, squares, squared side lengths and
// the diagonal cross product, then abs of the cross product and rhombus test.
module qpa_front #(
    parameter int COORD_WIDTH = 16,
    parameter int SQ_W        = 33,
    parameter int CR_W        = 35
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [3:0][COORD_WIDTH-1:0]    xs,
    input  wire logic [3:0][COORD_WIDTH-1:0]    ys,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [3:0][SQ_W-1:0]                out_sq,
    output qpa_pkg::qpa_side_t                  out_side
);
    import qpa_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int DW    = CW + 1;           // signed coordinate difference
    localparam int PW    = 2 * CW;           // square of a side difference
    localparam int SUM_W = 2 * CW + 1;       // exact squared side length
    localparam int CPW   = 2 * CW + 2;       // signed diagonal product
    localparam int CRX_W = 2 * CW + 3;       // exact cross product
    localparam int AX_W  = (CR_W > AREA_W) ? CR_W : AREA_W;

    // Stage valid bits and per-stage advance
    logic [3:0] v_reg;
    logic [3:0] en;

    always_comb begin
        en[3] = !v_reg[3] || out_ready;
        en[2] = !v_reg[2] || en[3];
        en[1] = !v_reg[1] || en[2];
        en[0] = !v_reg[0] || en[1];
    end

    assign in_ready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) v_reg[0] <= in_valid;
            if (en[1]) v_reg[1] <= v_reg[0];
            if (en[2]) v_reg[2] <= v_reg[1];
            if (en[3]) v_reg[3] <= v_reg[2];
        end
    end

    // Stage 1: absolute side differences and signed diagonal differences
    logic        [CW-1:0] adx_reg [4];
    logic        [CW-1:0] ady_reg [4];
    logic signed [DW-1:0] d1x_reg, d1y_reg, d2x_reg, d2y_reg;
    logic        [CW-1:0] adx_next [4];
    logic        [CW-1:0] ady_next [4];

    always_comb begin
        logic signed [DW-1:0] ddx, ddy;
        for (int k = 0; k < 4; k++) begin
            ddx = DW'($signed(xs[k])) - DW'($signed(xs[(k + 1) % 4]));
            ddy = DW'($signed(ys[k])) - DW'($signed(ys[(k + 1) % 4]));
            adx_next[k] = ddx[DW-1] ? CW'(-ddx) : CW'(ddx);
            ady_next[k] = ddy[DW-1] ? CW'(-ddy) : CW'(ddy);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            adx_reg <= adx_next;
            ady_reg <= ady_next;
            d1x_reg <= DW'($signed(xs[0])) - DW'($signed(xs[2]));
            d1y_reg <= DW'($signed(ys[0])) - DW'($signed(ys[2]));
            d2x_reg <= DW'($signed(xs[1])) - DW'($signed(xs[3]));
            d2y_reg <= DW'($signed(ys[1])) - DW'($signed(ys[3]));
        end
    end

    // Stage 2: squares and diagonal products
    logic        [PW-1:0]  sqx_reg [4];
    logic        [PW-1:0]  sqy_reg [4];
    logic signed [CPW-1:0] p1_reg, p2_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            for (int k = 0; k < 4; k++) begin
                sqx_reg[k] <= PW'(adx_reg[k]) * PW'(adx_reg[k]);
                sqy_reg[k] <= PW'(ady_reg[k]) * PW'(ady_reg[k]);
            end
            p1_reg <= CPW'(d1x_reg) * CPW'(d2y_reg);
            p2_reg <= CPW'(d1y_reg) * CPW'(d2x_reg);
        end
    end

    // Stage 3: squared side lengths and cross product, wrapped to SQ_W and CR_W bits
    logic        [SQ_W-1:0] sq3_reg [4];
    logic signed [CR_W-1:0] cr_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            for (int k = 0; k < 4; k++) begin
                sq3_reg[k] <= SQ_W'(SUM_W'(sqx_reg[k]) + SUM_W'(sqy_reg[k]));
            end
            cr_reg <= CR_W'(CRX_W'(p1_reg) - CRX_W'(p2_reg));
        end
    end

    // Stage 4: magnitude of the cross product, equal-sides test
    logic [SQ_W-1:0] sq4_reg [4];
    qpa_side_t       side_reg;
    logic [CR_W-1:0] cr_abs;
    logic [AX_W-1:0] cr_ext;

    always_comb begin
        cr_abs = cr_reg[CR_W-1] ? CR_W'(-cr_reg) : CR_W'(cr_reg);
        cr_ext = AX_W'(cr_abs);
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            sq4_reg              <= sq3_reg;
            side_reg.double_area <= cr_ext[AREA_W-1:0];
            side_reg.is_rhombus  <= (sq3_reg[0] == sq3_reg[1]) &&
                                    (sq3_reg[1] == sq3_reg[2]) &&
                                    (sq3_reg[2] == sq3_reg[3]);
        end
    end

    assign out_valid = v_reg[3];
    assign out_side  = side_reg;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            out_sq[k] = sq4_reg[k];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/qpa_sqrt.sv */
`timescale 1ns / 1ps
`default_nettype none

// Four-lane floor square root, one root bit per stage, MSB first.
// Remainder rem = n - r^2; a bit k is kept when rem >= (r << (k+1)) + 4^k.
module qpa_sqrt #(
    parameter int SQ_W = 33,
    parameter int RT_W = 17
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [3:0][SQ_W-1:0]        in_sq,
    input  wire qpa_pkg::qpa_side_t          in_side,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [3:0][RT_W-1:0]             out_root,
    output qpa_pkg::qpa_side_t               out_side
);
    import qpa_pkg::*;

    localparam int CD_W = 2 * RT_W + 1;

    logic [SQ_W-1:0] rem_reg  [RT_W][4];
    logic [RT_W-1:0] root_reg [RT_W][4];
    qpa_side_t       side_reg [RT_W];
    logic [RT_W-1:0] v_reg;
    wire  [RT_W:0]   en;

    assign en[RT_W] = out_ready;
    assign in_ready = en[0];

    for (genvar j = 0; j < RT_W; j++) begin : g_stage
        localparam int K = RT_W - 1 - j;

        logic [SQ_W-1:0] rem_in  [4];
        logic [RT_W-1:0] root_in [4];
        qpa_side_t       side_in;
        logic            v_in;
        logic [SQ_W-1:0] rem_next  [4];
        logic [RT_W-1:0] root_next [4];

        assign en[j] = !v_reg[j] || en[j+1];

        // Stage input: the front end for the first bit, else the stage above
        if (j == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < 4; l++) begin
                    rem_in[l]  = in_sq[l];
                    root_in[l] = '0;
                end
                side_in = in_side;
                v_in    = in_valid;
            end
        end else begin : g_rest
            always_comb begin
                rem_in  = rem_reg[j-1];
                root_in = root_reg[j-1];
                side_in = side_reg[j-1];
                v_in    = v_reg[j-1];
            end
        end

        // Trial subtract for root bit K in each lane
        always_comb begin
            logic [CD_W-1:0] cand;
            for (int l = 0; l < 4; l++) begin
                cand = (CD_W'(root_in[l]) << (K + 1)) | (CD_W'(1) << (2 * K));
                if (CD_W'(rem_in[l]) >= cand) begin
                    rem_next[l]  = SQ_W'(CD_W'(rem_in[l]) - cand);
                    root_next[l] = root_in[l] | (RT_W'(1) << K);
                end else begin
                    rem_next[l]  = rem_in[l];
                    root_next[l] = root_in[l];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en[j]) begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[j]) begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
                side_reg[j] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[RT_W-1];
    assign out_side  = side_reg[RT_W-1];

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            out_root[l] = root_reg[RT_W-1][l];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/qpa_tail.sv */
`timescale 1ns / 1ps
`default_nettype none

// Output stage: perimeter sum, opposite-side test, result register.
module qpa_tail #(
    parameter int RT_W = 17
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [3:0][RT_W-1:0]        in_root,
    input  wire qpa_pkg::qpa_side_t          in_side,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [qpa_pkg::OUT_DATA_W-1:0]   out_data
);
    import qpa_pkg::*;

    localparam int PS_W = RT_W + 2;
    localparam int PX_W = (PS_W > PERIM_W) ? PS_W : PERIM_W;
    localparam int TS_W = RT_W + 1;

    logic                  valid_reg;
    logic [PERIM_W-1:0]    perim_reg;
    qpa_side_t             side_reg;
    logic                  tang_reg;

    logic [PX_W-1:0]       perim_full;
    logic [TS_W-1:0]       sum_ac, sum_bd;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        perim_full = PX_W'(PS_W'(in_root[0]) + PS_W'(in_root[1]) +
                           PS_W'(in_root[2]) + PS_W'(in_root[3]));
        sum_ac     = TS_W'(in_root[0]) + TS_W'(in_root[2]);
        sum_bd     = TS_W'(in_root[1]) + TS_W'(in_root[3]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            perim_reg <= perim_full[PERIM_W-1:0];
            side_reg  <= in_side;
            tang_reg  <= (sum_ac == sum_bd);
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = {2'b00, tang_reg, side_reg.is_rhombus,
                        side_reg.double_area, perim_reg};

endmodule

`default_nettype wire

/* hw/rtl/quadrilateral_perimeter_area.sv */
// Quadrilateral perimeter, doubled area and shape flags, fixed point.
//
// Input channel s_axis_*: one beat carries the four vertices A, B, C, D as
// signed Q8.8 coordinates (COORD_WIDTH bits each). Result channel m_axis_*:
// one beat per input beat with the perimeter (sum of the four floor side
// lengths, Q8.8), twice the area (|AC x BD|, Q16.16), a rhombus flag (all
// squared sides equal) and a tangential flag (opposite side sums equal).
//
// Throughput: one quadrilateral per cycle while the receiver keeps
// m_axis_tready high. Four front stages build the squared sides and the
// cross product, the square root takes one stage per root bit (RT_W =
// (min(2*COORD_WIDTH+1, 64)+1)/2 root bits), and one output register follows.
//
// Reset empties every stage; s_axis_tready is high in the first cycle after
// reset. When the receiver holds m_axis_tready low the result stays on the
// port, and earlier stages keep filling up their empty slots; s_axis_tready
// falls only once every stage holds a beat.
`timescale 1ns / 1ps
`default_nettype none

module quadrilateral_perimeter_area #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // ax, bx, cx, dx, ay, by, cy, dy from the lowest bit up
    input  wire logic [8*COORD_WIDTH-1:0]      s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // perimeter[18:0], double_area[51:19], is_rhombus[52], is_tangential[53]
    output logic [qpa_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import qpa_pkg::*;

    localparam int SQ_W = (2 * COORD_WIDTH + 1 > 64) ? 64 : 2 * COORD_WIDTH + 1;
    localparam int CR_W = (2 * COORD_WIDTH + 3 > 64) ? 64 : 2 * COORD_WIDTH + 3;
    localparam int RT_W = (SQ_W + 1) / 2;

    logic [3:0][COORD_WIDTH-1:0] xs, ys;
    logic                        fr_valid, fr_ready;
    logic [3:0][SQ_W-1:0]        fr_sq;
    qpa_side_t                   fr_side;
    logic                        rt_valid, rt_ready;
    logic [3:0][RT_W-1:0]        rt_root;
    qpa_side_t                   rt_side;

    // Unpack the vertex beat
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            xs[k] = s_axis_tdata[k*COORD_WIDTH +: COORD_WIDTH];
            ys[k] = s_axis_tdata[(k+4)*COORD_WIDTH +: COORD_WIDTH];
        end
    end

    qpa_front #(
        .COORD_WIDTH(COORD_WIDTH),
        .SQ_W       (SQ_W),
        .CR_W       (CR_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .xs       (xs),
        .ys       (ys),
        .out_valid(fr_valid),
        .out_ready(fr_ready),
        .out_sq   (fr_sq),
        .out_side (fr_side)
    );

    qpa_sqrt #(
        .SQ_W(SQ_W),
        .RT_W(RT_W)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (fr_valid),
        .in_ready (fr_ready),
        .in_sq    (fr_sq),
        .in_side  (fr_side),
        .out_valid(rt_valid),
        .out_ready(rt_ready),
        .out_root (rt_root),
        .out_side (rt_side)
    );

    qpa_tail #(
        .RT_W(RT_W)
    ) u_tail (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (rt_valid),
        .in_ready (rt_ready),
        .in_root  (rt_root),
        .in_side  (rt_side),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_data (m_axis_tdata)
    );

endmodule

`default_nettype wire

/* hw/rtl/qpa_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module qpa_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_axis_tready,
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic [qpa_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import qpa_pkg::*;

    localparam int RHOMB_BIT = PERIM_W + AREA_W;
    localparam int TANG_BIT  = RHOMB_BIT + 1;

    // A held result beat keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // Reset leaves the pipe empty and open
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid && s_axis_tready)
        else $error("pipe not empty after reset");

    // Equal sides give equal opposite sums
    a_rhomb_tang: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[RHOMB_BIT] |-> m_axis_tdata[TANG_BIT])
        else $error("rhombus without tangential flag");

    // Equal sides give a perimeter of four times one side, so a multiple of four
    a_rhomb_perim: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[RHOMB_BIT] |-> m_axis_tdata[1:0] == 2'b00)
        else $error("rhombus perimeter not a multiple of four");

endmodule

bind quadrilateral_perimeter_area qpa_checker u_qpa_checker (.*);

`default_nettype wire
